// ===== rtl/core/sta_pkg.sv =====
// Shared types and constants of the sparse triplet adder.
package sta_pkg;

	// Field widths of the beats on the item and result channels.
	localparam int unsigned MODE_W = 2;
	localparam int unsigned IDX_W  = 5;
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned SUM_W  = 17;
	localparam int unsigned ST_W   = 2;

	// Configuration port widths.
	localparam int unsigned DIM_W     = 6;
	localparam int unsigned CFG_IDX_W = 2;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_TERM     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_MISMATCH = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

	// One stored nonzero term.
	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} term_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic start;
		logic step;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
		logic final_step;
	} dp_status_t;

endpackage

// ===== rtl/core/sta_if.sv =====
// Valid/ready channel interfaces for items and results.
interface sta_in_if
	import sta_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic [IDX_W-1:0]        row;
	logic [IDX_W-1:0]        col;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, mode, row, col, value, input ready);
	modport sink (input valid, mode, row, col, value, output ready);
endinterface

interface sta_out_if
	import sta_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [SUM_W-1:0] sum;
	logic                    last;

	modport source (output valid, status, out_row, out_col, sum, last, input ready);
	modport sink (input valid, status, out_row, out_col, sum, last, output ready);
endinterface

// ===== rtl/core/sta_store.sv =====
// Term store: one write port, one read port with registered read data.
module sta_store
	import sta_pkg::*;
#(
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  term_t                    wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output term_t                    rdata
);

	term_t mem_q [DEPTH];
	term_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered every cycle.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sta_dp.sv =====
// Datapath: configuration, term stores, counts, merge compare and add, result register.
module sta_dp
	import sta_pkg::*;
#(
	parameter int unsigned MAX_TERMS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration writes
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [DIM_W-1:0]        cfg_data,
	// Item payload
	input  logic [IDX_W-1:0]        in_row,
	input  logic [IDX_W-1:0]        in_col,
	input  logic signed [VAL_W-1:0] in_value,
	// Controller link
	input  dp_cmd_t                 cmd,
	output dp_status_t              status,
	// Result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ST_W-1:0]         out_status,
	output logic [IDX_W-1:0]        out_row,
	output logic [IDX_W-1:0]        out_col,
	output logic signed [SUM_W-1:0] out_sum,
	output logic                    out_last
);

	localparam int unsigned AW = $clog2(MAX_TERMS);
	localparam int unsigned CW = $clog2(MAX_TERMS + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_TERMS);

	logic [DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [CW-1:0]    a_cnt_q, b_cnt_q;
	logic [CW-1:0]    a_idx_q, b_idx_q;
	logic [CW-1:0]    a_idx_d, b_idx_d;
	term_t            wterm;
	term_t            rd_a, rd_b;
	logic             wr_a, wr_b;

	logic a_left, b_left, same_pos, a_first, take_a, take_b;
	logic dims_match, both_empty, merge_last;
	logic [ST_W-1:0]         res_status;
	logic [IDX_W-1:0]        res_row, res_col;
	logic signed [SUM_W-1:0] res_sum;

	logic                    out_valid_q;
	logic [ST_W-1:0]         out_status_q;
	logic [IDX_W-1:0]        out_row_q, out_col_q;
	logic signed [SUM_W-1:0] out_sum_q;
	logic                    out_last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_W'(1);
			cols_a_q <= DIM_W'(1);
			rows_b_q <= DIM_W'(1);
			cols_b_q <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ROWS_A: rows_a_q <= cfg_data;
				CFG_COLS_A: cols_a_q <= cfg_data;
				CFG_ROWS_B: rows_b_q <= cfg_data;
				CFG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Loads go to the next free entry; a full store ignores them.
	assign wterm = '{row: in_row, col: in_col, value: in_value};
	assign wr_a  = cmd.load_a && (a_cnt_q < CNT_FULL);
	assign wr_b  = cmd.load_b && (b_cnt_q < CNT_FULL);

	// Merge decision on the current heads of both lists.
	always_comb begin
		a_left   = a_idx_q < a_cnt_q;
		b_left   = b_idx_q < b_cnt_q;
		same_pos = (rd_a.row == rd_b.row) && (rd_a.col == rd_b.col);
		a_first  = (rd_a.row < rd_b.row) || ((rd_a.row == rd_b.row) && (rd_a.col < rd_b.col));
		take_a   = a_left && (!b_left || same_pos || a_first);
		take_b   = b_left && (!a_left || same_pos || !a_first);
	end

	// Next head indexes; they also address the stores so the data is ready next cycle.
	always_comb begin
		if (cmd.start) begin
			a_idx_d = '0;
			b_idx_d = '0;
		end else begin
			a_idx_d = (cmd.step && take_a) ? a_idx_q + 1'b1 : a_idx_q;
			b_idx_d = (cmd.step && take_b) ? b_idx_q + 1'b1 : b_idx_q;
		end
	end

	sta_store #(.DEPTH(MAX_TERMS)) u_store_a (
		.clk   (clk),
		.we    (wr_a),
		.waddr (a_cnt_q[AW-1:0]),
		.wdata (wterm),
		.raddr (a_idx_d[AW-1:0]),
		.rdata (rd_a)
	);

	sta_store #(.DEPTH(MAX_TERMS)) u_store_b (
		.clk   (clk),
		.we    (wr_b),
		.waddr (b_cnt_q[AW-1:0]),
		.wdata (wterm),
		.raddr (b_idx_d[AW-1:0]),
		.rdata (rd_b)
	);

	// Head indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_idx_q <= '0;
			b_idx_q <= '0;
		end else begin
			a_idx_q <= a_idx_d;
			b_idx_q <= b_idx_d;
		end
	end

	// Result of this step and whether it ends the merge.
	always_comb begin
		dims_match = (rows_a_q == rows_b_q) && (cols_a_q == cols_b_q);
		both_empty = (a_cnt_q == '0) && (b_cnt_q == '0);
		merge_last = !(a_idx_d < a_cnt_q) && !(b_idx_d < b_cnt_q);
		res_row    = '0;
		res_col    = '0;
		res_sum    = '0;
		if (!dims_match) begin
			res_status = ST_MISMATCH;
		end else if (both_empty) begin
			res_status = ST_EMPTY;
		end else begin
			res_status = ST_TERM;
			res_row    = take_a ? rd_a.row : rd_b.row;
			res_col    = take_a ? rd_a.col : rd_b.col;
			res_sum    = (take_a ? {rd_a.value[VAL_W-1], rd_a.value} : '0)
			           + (take_b ? {rd_b.value[VAL_W-1], rd_b.value} : '0);
		end
	end

	assign status.slot_free  = !out_valid_q || out_ready;
	assign status.final_step = !dims_match || both_empty || merge_last;

	// Term counts; the final step of a merge clears both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
		end else if (cmd.step && status.final_step) begin
			a_cnt_q <= '0;
			b_cnt_q <= '0;
		end else begin
			if (wr_a) begin
				a_cnt_q <= a_cnt_q + 1'b1;
			end
			if (wr_b) begin
				b_cnt_q <= b_cnt_q + 1'b1;
			end
		end
	end

	// Result register: holds one beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_status_q <= res_status;
			out_row_q    <= res_row;
			out_col_q    <= res_col;
			out_sum_q    <= res_sum;
			out_last_q   <= status.final_step;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_sum    = out_sum_q;
	assign out_last   = out_last_q;

endmodule

// ===== rtl/core/sta_ctrl.sv =====
// Controller: accepts items, issues load and start commands, steps the merge.
module sta_ctrl
	import sta_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] in_mode,
	output dp_cmd_t           cmd,
	input  dp_status_t        status
);

	typedef enum logic {
		S_IDLE,
		S_MERGE
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode the accepted item and step the merge while the result slot is free.
	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (in_mode)
				MODE_LOAD_A: cmd.load_a = 1'b1;
				MODE_LOAD_B: cmd.load_b = 1'b1;
				MODE_START:  cmd.start  = 1'b1;
				default: ;
			endcase
		end
		cmd.step = (state_q == S_MERGE) && status.slot_free;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					if (cmd.step && status.final_step) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/sparse_triplet_add_top.sv =====
// Load items give no result; the item channel stays ready, so the next item is taken in the
// following cycle. A start item moves the controller into its merge state; from there each
// step puts a result in the output register, one result per cycle while the sink takes them,
// and the item channel is not ready until the final step. The output register sets the pace.
// Reset clears both term counts and the merge controller and sets all dimensions to 1;
// the term stores hold no defined contents until loaded.
module sparse_triplet_add_top
	import sta_pkg::*;
#(
	parameter int unsigned MAX_TERMS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DIM_W-1:0]     cfg_data,
	sta_in_if.sink               item,
	sta_out_if.source            result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	sta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.in_mode  (item.mode),
		.cmd      (cmd),
		.status   (status)
	);

	sta_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_row     (item.row),
		.in_col     (item.col),
		.in_value   (item.value),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_status (result.status),
		.out_row    (result.out_row),
		.out_col    (result.out_col),
		.out_sum    (result.sum),
		.out_last   (result.last)
	);

endmodule

// ===== rtl/core/sta_checker.sv =====
// Port-level checker of the sparse triplet adder and its bind to the top level.
module sta_checker
	import sta_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [MODE_W-1:0]       in_mode,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [ST_W-1:0]         out_status,
	input logic [IDX_W-1:0]        out_row,
	input logic [IDX_W-1:0]        out_col,
	input logic signed [SUM_W-1:0] out_sum,
	input logic                    out_last
);

	logic       start_beat, last_beat;
	logic [1:0] pend_q;

	assign start_beat = in_valid && in_ready && (in_mode == MODE_START);
	assign last_beat  = out_valid && out_ready && out_last;

	// Merges started whose last result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (start_beat && !last_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (last_beat && !start_beat) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// A result only appears on behalf of a started merge.
	a_result_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result beat without a pending merge");

	// Empty and mismatch results stand alone and carry zero fields.
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_status != ST_TERM)) |->
			(out_last && (out_sum == '0) && (out_row == '0) && (out_col == '0)))
		else $error("status result is not a lone zero beat");

	// No more than one finished merge may wait behind a running one.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		start_beat |-> (pend_q != 2'd2))
		else $error("start accepted while two merges are pending");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(out_status) && $stable(out_row) && $stable(out_col)
			 && $stable(out_sum) && $stable(out_last)))
		else $error("stalled result beat changed");

endmodule

bind sparse_triplet_add_top sta_checker u_sta_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.in_mode    (item.mode),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_status (result.status),
	.out_row    (result.out_row),
	.out_col    (result.out_col),
	.out_sum    (result.sum),
	.out_last   (result.last)
);
